// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers. Each expects clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/sstm_pkg.sv =====
`timescale 1ns / 1ps
package sstm_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_UPD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic div;
		logic upd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

	localparam logic OP_APPLY = 1'b0;
	localparam logic OP_SAVE  = 1'b1;

	localparam logic CFG_TRAVEL   = 1'b0;
	localparam logic CFG_MAX_BIAS = 1'b1;

	localparam logic [9:0] TRAVEL_RESET   = 10'd500;
	localparam logic [9:0] MAX_BIAS_RESET = 10'd100;

	localparam logic signed [12:0] PULSE_MIN = 13'sd500;
	localparam logic signed [12:0] PULSE_MAX = 13'sd2500;

	localparam logic signed [7:0] STICK_MIN = -8'sd100;
	localparam logic signed [7:0] STICK_MAX = 8'sd100;
	localparam logic [7:0] SPAN_MAX = 8'd200;

	// floor(x/100) = floor((x>>2) * RECIP_25 >> RECIP_25_SHIFT) for x < 2^18
	localparam logic [16:0] RECIP_25 = 17'd83887;
	localparam int RECIP_25_SHIFT = 21;

	// floor(y/625) = (y * RECIP_625) >> RECIP_625_SHIFT for y < 2^19
	localparam logic [18:0] RECIP_625 = 19'd429497;
	localparam int RECIP_625_SHIFT = 28;

	localparam logic [11:0] DUTY_MAX = 12'd511;

endpackage

// ===== hw/rtl/servo_steer_trim_mapper.sv =====
`timescale 1ns / 1ps
// Steering servo trim unit.
// Input channel (in_valid / in_stall): one beat carries op and a signed stick value rx.
//   op apply maps rx (saturated to -100..100) onto center +/- travel_us for the
//   pulse and onto bias zero +/- max_bias for the mix bias. op save adopts that
//   pair (after a save, the last pair), clamped, as new center and bias zero; flags store_request.
// Output channel (out_valid / out_stall): one beat per input beat with pulse,
//   12-bit duty at 50 Hz, bias, stored center and bias zero, store flag.
// Config port: cfg_we writes cfg_wdata into travel_us (index 0) or max_bias
//   (index 1); write only while no item is in flight.
// Flow: the controller walks one item at a time through product, reciprocal
//   divide, state update and output load; a new beat is taken only once the
//   previous one is in the output register.
// Stall: the output register holds its beat while out_stall is high; the next
//   item is taken and worked meanwhile, then waits in the output-load step.
// Reset: center and last pulse go to CENTER_DEFAULT_US, bias values to zero,
//   save latch clears, travel_us to 500, max_bias to 100, no beat is valid.
module servo_steer_trim_mapper #(
	parameter int CENTER_DEFAULT_US = 1500
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_idx,
	input  logic [9:0] cfg_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  logic op,
	input  logic signed [7:0] rx,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [12:0] pulse_us,
	output logic [11:0] duty12,
	output logic signed [11:0] bias_out,
	output logic [11:0] center_now,
	output logic signed [10:0] bias_zero_now,
	output logic store_request
);
	import sstm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: one item at a time
	sstm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic, trim state and output register
	sstm_dp #(
		.CENTER_DEFAULT_US (CENTER_DEFAULT_US)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.op            (op),
		.rx            (rx),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pulse_us      (pulse_us),
		.duty12        (duty12),
		.bias_out      (bias_out),
		.center_now    (center_now),
		.bias_zero_now (bias_zero_now),
		.store_request (store_request)
	);

endmodule

// ===== hw/rtl/sstm_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sstm_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sstm_pkg::sts_t sts,
	output sstm_pkg::cmd_t cmd
);
	import sstm_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register can take the beat
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`ASSERT_NEXT(a_div_then_upd, state_q == ST_DIV, state_q == ST_UPD,
		"division step not followed by update")
	`ASSERT_NEXT(a_load_single, cmd.load, !cmd.load && state_q == ST_DIV,
		"second beat taken while busy")
	`ASSERT_IMPL(a_busy_stalls, state_q != ST_IDLE, in_stall,
		"input not stalled while an item is in flight")

endmodule

// ===== hw/rtl/sstm_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sstm_dp #(
	parameter int CENTER_DEFAULT_US = 1500
) (
	input  logic clk,
	input  logic arst_n,
	input  sstm_pkg::cmd_t cmd,
	output sstm_pkg::sts_t sts,
	input  logic cfg_we,
	input  logic cfg_idx,
	input  logic [9:0] cfg_wdata,
	input  logic op,
	input  logic signed [7:0] rx,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [12:0] pulse_us,
	output logic [11:0] duty12,
	output logic signed [11:0] bias_out,
	output logic [11:0] center_now,
	output logic signed [10:0] bias_zero_now,
	output logic store_request
);
	import sstm_pkg::*;

	logic [9:0] travel_q, max_bias_q;

	logic op_q;
	logic [17:0] prod_p_q, prod_b_q;
	logic [10:0] qp_q, qb_q;
	logic [18:0] y_q;

	logic [11:0] center_q;
	logic signed [10:0] bz_q;
	logic signed [12:0] last_pulse_q;
	logic signed [11:0] last_bias_q;
	logic save_latch_q;

	logic out_valid_q;
	logic signed [12:0] pulse_q;
	logic [11:0] duty_q;
	logic signed [11:0] bias_q;
	logic [11:0] center_out_q;
	logic signed [10:0] bz_out_q;
	logic store_q;

	logic [7:0] t_d;
	logic signed [8:0] rx_ext;
	logic [32:0] qp_full, qb_full;
	logic signed [13:0] map_p_w;
	logic signed [12:0] map_b_w;
	logic signed [12:0] map_p, src_p, c_p, new_p, clamp_new_p;
	logic signed [11:0] map_b, src_b, c_b, mb_s;
	logic [11:0] pc;
	logic [23:0] prod24;
	logic [37:0] duty_full;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_q <= TRAVEL_RESET;
			max_bias_q <= MAX_BIAS_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_TRAVEL:   travel_q <= cfg_wdata;
				CFG_MAX_BIAS: max_bias_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// saturate stick and offset to 0..200
	always_comb begin
		rx_ext = {rx[7], rx};
		if (rx < STICK_MIN) begin
			t_d = 8'd0;
		end else if (rx > STICK_MAX) begin
			t_d = SPAN_MAX;
		end else begin
			t_d = 8'(rx_ext + 9'sd100);
		end
	end

	assign qp_full = 33'(prod_p_q[17:2]) * 33'(RECIP_25);
	assign qb_full = 33'(prod_b_q[17:2]) * 33'(RECIP_25);

	always_comb begin
		map_p_w = $signed({3'b0, qp_q}) + $signed({2'b0, center_q})
			- $signed({4'b0, travel_q});
		map_p = map_p_w[12:0];
		map_b_w = $signed({2'b0, qb_q}) + $signed({bz_q[10], bz_q[10], bz_q})
			- $signed({3'b0, max_bias_q});
		map_b = map_b_w[11:0];

		src_p = save_latch_q ? last_pulse_q : map_p;
		src_b = save_latch_q ? last_bias_q : map_b;

		if (src_p < PULSE_MIN) c_p = PULSE_MIN;
		else if (src_p > PULSE_MAX) c_p = PULSE_MAX;
		else c_p = src_p;

		mb_s = $signed({2'b0, max_bias_q});
		if (src_b < -mb_s) c_b = -mb_s;
		else if (src_b > mb_s) c_b = mb_s;
		else c_b = src_b;

		new_p = (op_q == OP_SAVE) ? c_p : map_p;
		if (new_p < PULSE_MIN) clamp_new_p = PULSE_MIN;
		else if (new_p > PULSE_MAX) clamp_new_p = PULSE_MAX;
		else clamp_new_p = new_p;
		pc = clamp_new_p[11:0];
		// pulse * 4095 as shift and subtract
		prod24 = {pc, 12'b0} - {12'b0, pc};
	end

	assign duty_full = 38'(y_q) * 38'(RECIP_625);

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			prod_p_q <= {10'b0, t_d} * {8'b0, travel_q};
			prod_b_q <= {10'b0, t_d} * {8'b0, max_bias_q};
		end
		if (cmd.div) begin
			qp_q <= qp_full[RECIP_25_SHIFT +: 11];
			qb_q <= qb_full[RECIP_25_SHIFT +: 11];
		end
		if (cmd.upd) begin
			y_q <= prod24[23:5];
		end
		if (cmd.out_load) begin
			pulse_q <= last_pulse_q;
			duty_q <= {2'b0, duty_full[RECIP_625_SHIFT +: 10]};
			bias_q <= last_bias_q;
			center_out_q <= center_q;
			bz_out_q <= bz_q;
			store_q <= op_q;
		end
	end

	// trim state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= 12'(CENTER_DEFAULT_US);
			bz_q <= '0;
			last_pulse_q <= 13'(CENTER_DEFAULT_US);
			last_bias_q <= '0;
			save_latch_q <= 1'b0;
		end else if (cmd.upd) begin
			if (op_q == OP_APPLY) begin
				last_pulse_q <= map_p;
				last_bias_q <= map_b;
				save_latch_q <= 1'b0;
			end else begin
				center_q <= c_p[11:0];
				bz_q <= c_b[10:0];
				last_pulse_q <= c_p;
				last_bias_q <= c_b;
				save_latch_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign pulse_us = pulse_q;
	assign duty12 = duty_q;
	assign bias_out = bias_q;
	assign center_now = center_out_q;
	assign bias_zero_now = bz_out_q;
	assign store_request = store_q;

	`ASSERT_ALWAYS(a_center_range, center_q >= 12'd500 && center_q <= 12'd2500, "center out of range")
	`ASSERT_IMPL(a_duty_range, out_valid_q, duty_q <= DUTY_MAX, "duty above clamped maximum")
	`ASSERT_IMPL(a_save_coherent, out_valid_q && store_q, pulse_q == $signed({1'b0, center_out_q}) && bias_q == $signed({bz_out_q[10], bz_out_q}), "save beat disagrees with stored center")

endmodule

// ===== tb/sv/sstm_checker.sv =====
`timescale 1ns / 1ps
module sstm_checker #(
	parameter int CENTER_DEFAULT_US = 1500
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_idx,
	input  logic [9:0] cfg_wdata,
	input  logic in_valid,
	input  logic in_stall,
	input  logic op,
	input  logic signed [7:0] rx,
	input  logic out_valid,
	input  logic out_stall,
	input  logic signed [12:0] pulse_us,
	input  logic [11:0] duty12,
	input  logic signed [11:0] bias_out,
	input  logic [11:0] center_now,
	input  logic signed [10:0] bias_zero_now,
	input  logic store_request,
	output int mismatch_count,
	output int pending_count,
	output int checked_count
);
	import sstm_pkg::*;

	typedef struct packed {
		logic signed [12:0] pulse;
		logic [11:0] duty;
		logic signed [11:0] bias;
		logic [11:0] center;
		logic signed [10:0] bias_zero;
		logic store;
	} trim_beat_t;

	int travel_lim = 0;
	int bias_lim = 0;
	int center_pw = 0;
	int zero_bias = 0;
	int pulse_held = 0;
	int bias_held = 0;
	bit save_armed = 1'b0;
	int mism = 0;
	int checked = 0;
	trim_beat_t trim_q[$];

	function automatic int clamp_to(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Linear map of a saturated stick value onto mid +/- half.
	function automatic int span_point(int s, int mid, int half);
		return (s + 100) * (2 * half) / 200 + mid - half;
	endfunction

	function automatic void show_beat(string tag, trim_beat_t b);
		$display("  %s pulse=%0d duty=%0d bias=%0d center=%0d zero=%0d store=%0b",
			tag, b.pulse, b.duty, b.bias, b.center, b.bias_zero, b.store);
	endfunction

	// Advance the trim state by one stick beat and return the beat it produces.
	function automatic trim_beat_t advance_trim(logic op_v, logic signed [7:0] rx_v);
		int s;
		int duty_v;
		trim_beat_t r;
		s = clamp_to(int'(rx_v), int'(STICK_MIN), int'(STICK_MAX));
		if (op_v == OP_APPLY || !save_armed) begin
			pulse_held = span_point(s, center_pw, travel_lim);
			bias_held = span_point(s, zero_bias, bias_lim);
		end
		if (op_v == OP_APPLY) begin
			save_armed = 1'b0;
		end else begin
			center_pw = clamp_to(pulse_held, int'(PULSE_MIN), int'(PULSE_MAX));
			zero_bias = clamp_to(bias_held, -bias_lim, bias_lim);
			pulse_held = center_pw;
			bias_held = zero_bias;
			save_armed = 1'b1;
		end
		duty_v = clamp_to(pulse_held, int'(PULSE_MIN), int'(PULSE_MAX)) * 4095 / 20000;
		r.pulse = pulse_held[12:0];
		r.duty = duty_v[11:0];
		r.bias = bias_held[11:0];
		r.center = center_pw[11:0];
		r.bias_zero = zero_bias[10:0];
		r.store = (op_v == OP_SAVE);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		trim_beat_t got;
		trim_beat_t want;
		if (!arst_n) begin
			travel_lim = int'(TRAVEL_RESET);
			bias_lim = int'(MAX_BIAS_RESET);
			center_pw = clamp_to(CENTER_DEFAULT_US, int'(PULSE_MIN), int'(PULSE_MAX));
			zero_bias = 0;
			pulse_held = center_pw;
			bias_held = 0;
			save_armed = 1'b0;
			trim_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_idx == CFG_TRAVEL)
					travel_lim = int'(cfg_wdata);
				else
					bias_lim = int'(cfg_wdata);
			end
			if (in_valid && !in_stall)
				trim_q.push_back(advance_trim(op, rx));
			if (out_valid && !out_stall) begin
				got = {pulse_us, duty12, bias_out, center_now, bias_zero_now, store_request};
				if (trim_q.size() == 0) begin
					mism++;
					if (mism <= 10) begin
						$display("unexpected result beat:");
						show_beat("actual  ", got);
					end
				end else begin
					want = trim_q.pop_front();
					checked++;
					if (got !== want) begin
						mism++;
						if (mism <= 10) begin
							$display("result beat %0d mismatch:", checked);
							show_beat("expected", want);
							show_beat("actual  ", got);
						end
					end
				end
			end
		end
		mismatch_count <= mism;
		pending_count <= trim_q.size();
		checked_count <= checked;
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import sstm_pkg::*;

	localparam int CENTER_US = 1500;
	// Cycles to let pass after the last expected beat before touching the trims.
	localparam int SETTLE_CYCLES = 8;
	// Receiver hold-off used to back the block up into its input.
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_idx;
	logic [9:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic op;
	logic signed [7:0] rx;
	logic out_valid;
	logic out_stall;
	logic signed [12:0] pulse_us;
	logic [11:0] duty12;
	logic signed [11:0] bias_out;
	logic [11:0] center_now;
	logic signed [10:0] bias_zero_now;
	logic store_request;

	int mismatch_count;
	int pending_count;
	int checked_count;

	// Shared knobs between the sender, the receiver and the phase sequence.
	bit quiet_tail = 1'b0;
	bit burst_sender = 1'b0;
	bit hold_req = 1'b0;

	int stick_beats = 0;
	int save_beats = 0;
	int trim_settings = 1;
	int cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	servo_steer_trim_mapper #(
		.CENTER_DEFAULT_US(CENTER_US)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.rx(rx),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pulse_us(pulse_us),
		.duty12(duty12),
		.bias_out(bias_out),
		.center_now(center_now),
		.bias_zero_now(bias_zero_now),
		.store_request(store_request)
	);

	sstm_checker #(
		.CENTER_DEFAULT_US(CENTER_US)
	) u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.rx(rx),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pulse_us(pulse_us),
		.duty12(duty12),
		.bias_out(bias_out),
		.center_now(center_now),
		.bias_zero_now(bias_zero_now),
		.store_request(store_request),
		.mismatch_count(mismatch_count),
		.pending_count(pending_count),
		.checked_count(checked_count)
	);

	// Offer one stick beat and hold it until the block takes it. Afterwards drop
	// valid for a random burst now and then, scrambling the payload meanwhile.
	task automatic send_stick(input logic op_v, input logic signed [7:0] rx_v);
		in_valid <= 1'b1;
		op <= op_v;
		rx <= rx_v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		stick_beats++;
		if (op_v == OP_SAVE)
			save_beats++;
		if (!quiet_tail && !burst_sender && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			op <= 1'($urandom_range(0, 1));
			rx <= 8'($urandom_range(0, 255));
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every expected beat has come back, plus slack.
	task automatic settle_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both trim registers back to back; hold we high across the pair.
	task automatic write_trims(input int trv, input int bias);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_TRAVEL;
		cfg_wdata <= trv[9:0];
		@(posedge clk);
		cfg_idx <= CFG_MAX_BIAS;
		cfg_wdata <= bias[9:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly in range, with saturation edges, out-of-range sticks and full-range noise.
	function automatic logic signed [7:0] pick_stick();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: v = int'($urandom_range(0, 200)) - 100;
			6: v = $urandom_range(0, 1) ? 100 : -100;
			7: v = $urandom_range(0, 1) ? int'($urandom_range(101, 127))
				: -int'($urandom_range(101, 128));
			8: v = int'($urandom_range(0, 255)) - 128;
			default: v = int'($urandom_range(0, 4)) - 2;
		endcase
		return v[7:0];
	endfunction

	// Trim sessions: runs of applies broken by saves, some saves repeated.
	task automatic random_sticks(input int n);
		logic op_v;
		op_v = OP_APPLY;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0 || (op_v == OP_SAVE && $urandom_range(0, 2) == 0))
				op_v = OP_SAVE;
			else
				op_v = OP_APPLY;
			send_stick(op_v, pick_stick());
		end
	endtask

	// Push the center to both rails and pull the pulse past them.
	task automatic sweep_edges();
		send_stick(OP_APPLY, -8'sd128);
		send_stick(OP_SAVE, -8'sd128);
		send_stick(OP_APPLY, -8'sd128);
		send_stick(OP_SAVE, 8'sd127);
		send_stick(OP_APPLY, 8'sd127);
		send_stick(OP_APPLY, 8'sd0);
	endtask

	task automatic run_phase(input int trv, input int bias, input int n, input bit squeeze);
		settle_idle();
		write_trims(trv, bias);
		trim_settings++;
		sweep_edges();
		if (squeeze) begin
			// Back the output up for a long stretch while beats keep coming.
			burst_sender = 1'b1;
			hold_req = 1'b1;
			random_sticks(40);
			burst_sender = 1'b0;
			random_sticks(n - 40);
		end else begin
			random_sticks(n);
		end
	endtask

	// Receiver: pick a stall level and a run length, hold it, repeat.
	initial begin : receiver
		bit stall_v;
		int run_len;
		forever begin
			if (hold_req) begin
				stall_v = 1'b1;
				run_len = HOLD_OFF_CYCLES;
				hold_req = 1'b0;
			end else if (quiet_tail) begin
				stall_v = 1'b0;
				run_len = 1;
			end else if ($urandom_range(0, 2) == 0) begin
				stall_v = 1'b1;
				run_len = $urandom_range(1, 14);
			end else begin
				stall_v = 1'b0;
				run_len = $urandom_range(1, 20);
			end
			out_stall <= stall_v;
			repeat (run_len) @(posedge clk);
		end
	end

	// Watchdog: end a hung run.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d beats still expected", cycle_count, pending_count);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= CFG_TRAVEL;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		op <= OP_APPLY;
		rx <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass at reset trims: saturation, full rx bit patterns,
		// save with the latch clear, repeated save, center raised by a full-stick save.
		send_stick(OP_APPLY, 8'sd0);
		send_stick(OP_APPLY, -8'sd128);
		send_stick(OP_APPLY, 8'sd127);
		send_stick(OP_APPLY, -8'sd100);
		send_stick(OP_APPLY, 8'sd100);
		send_stick(OP_APPLY, -8'sd101);
		send_stick(OP_APPLY, 8'sd101);
		send_stick(OP_APPLY, -8'sd1);
		send_stick(OP_APPLY, 8'sd1);
		send_stick(OP_SAVE, -8'sd50);
		send_stick(OP_SAVE, 8'sd77);
		send_stick(OP_APPLY, 8'sd100);
		send_stick(OP_SAVE, 8'sd100);
		send_stick(OP_SAVE, 8'sd100);
		send_stick(OP_APPLY, 8'sd100);
		send_stick(OP_APPLY, 8'sd0);
		random_sticks(90);

		// Wide bias first, then zero limit: the stored bias zero stays until a save.
		run_phase(1023, 1023, 100, 1'b0);
		run_phase(0, 0, 100, 1'b0);
		run_phase(1000, 1000, 100, 1'b1);
		run_phase(1023, 0, 100, 1'b0);
		run_phase(0, 1000, 100, 1'b0);
		quiet_tail = 1'b1;
		run_phase($urandom_range(0, 1023), $urandom_range(0, 1023), 100, 1'b0);

		settle_idle();
		$display("covered %0d stick beats (%0d saves) over %0d trim settings,",
			stick_beats, save_beats, trim_settings);
		$display("with a long output hold-off; %0d result beats compared, %0d mismatches",
			checked_count, mismatch_count);
		if (mismatch_count == 0 && pending_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
